>>> hdl/bjct_pkg.sv
// Shared types and constants for the blocked jump count table.
package bjct_pkg;
   localparam int MAX_POSITIONS = 4096;
   localparam int REG_W = 13;
   localparam int POS_W = 12;
   localparam int LEN_W = 16;
   localparam int HOP_W = 13;
   localparam logic [HOP_W-1:0] HOP_MAX = 13'd8191;

   localparam logic [REG_W-1:0] ACTIVE_RST = 13'd4096;
   localparam logic [REG_W-1:0] BLOCK_RST  = 13'd64;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_BUILD  = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [0:0] CSR_ACTIVE = 1'b0;
   localparam logic [0:0] CSR_BLOCK  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic start;     // latch beat, init walk
      logic step;      // walk cycle: advance the table walk
      logic is_build;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic store_only; // load, or any op with nothing to walk
      logic walk_done;  // last entry processed this cycle
   } sts_type;
endpackage

>>> hdl/bjct_ctrl.sv
// Controller: sequences start, walk and result beat.
module bjct_ctrl
   import bjct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] in_op,
   output logic       out_valid,
   input  logic       out_ready,
   output cmd_type    cmd,
   input  sts_type    sts
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INIT = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       query_ff, query_in;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      query_in = query_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.start = 1'b1;
               query_in = (in_op == OP_QUERY);
               cmd.is_build = (in_op == OP_BUILD);
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            // walk bounds are set here from the registered beat
            if (sts.store_only) state_in = query_ff ? S_OUT : S_IDLE;
            else state_in = S_WALK;
         end
         S_WALK: begin
            cmd.step = 1'b1;
            if (sts.walk_done) state_in = query_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         query_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         query_ff <= query_in;
      end
   end
endmodule

>>> hdl/bjct_dp.sv
// Datapath: tables, block bounds, recompute and query walk.
module bjct_dp
   import bjct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [0:0]       csr_idx,
   input  logic [REG_W-1:0] csr_data,
   input  logic [1:0]       in_op,
   input  logic [POS_W-1:0] in_pos,
   input  logic [LEN_W-1:0] in_len,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic [HOP_W-1:0] hop_count
);
   localparam int AW = $clog2(MAX_POSITIONS);
   localparam int NW = AW + 1;
   localparam int TW = NW + 1 > LEN_W + 1 ? NW + 1 : LEN_W + 1;

   logic [LEN_W-1:0] jump_mem [MAX_POSITIONS];
   logic [NW-1:0]    exit_mem [MAX_POSITIONS];
   logic [HOP_W-1:0] hops_mem [MAX_POSITIONS];

   logic [REG_W-1:0] active_ff, bsize_ff;
   logic [NW-1:0]    n_ff, bs_ff;
   logic [NW-1:0]    cur_ff, cur_in;       // current entry (query: position)
   logic [NW-1:0]    bstart_ff, bstart_in; // start of current entry's block
   logic [NW-1:0]    bend_ff, bend_in;     // end of current entry's block
   logic [NW-1:0]    lower_ff, lower_in;   // walk stops below this
   logic [NW-1:0]    steps_ff, steps_in;
   logic [HOP_W-1:0] total_ff, total_in;
   logic             store_only_ff, store_only_in;
   logic [1:0]       op_ff;
   logic [POS_W-1:0] pos_ff;
   logic [1:0]       phase_ff, phase_in;   // 0 read, 1 read target, 2 write, 3 locate block

   logic [LEN_W-1:0] jrd_ff;
   logic [NW-1:0]    erd_ff;
   logic [HOP_W-1:0] hrd_ff;

   logic [AW-1:0]    rd_addr;
   logic [NW-1:0]    n_eff, bs_eff, ext_pos;
   logic [TW-1:0]    tgt_w;
   logic [LEN_W-1:0] len_use;
   logic             we;
   logic [AW-1:0]    wa;
   logic [NW-1:0]    wexit;
   logic [HOP_W-1:0] whops;
   logic             done;
   logic [HOP_W:0]   hsum;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RST;
         bsize_ff <= BLOCK_RST;
      end else if (csr_we) begin
         if (csr_idx == CSR_ACTIVE) active_ff <= csr_data;
         else bsize_ff <= csr_data;
      end
   end

   assign n_eff  = (active_ff > REG_W'(MAX_POSITIONS)) ? NW'(MAX_POSITIONS) : NW'(active_ff);
   assign bs_eff = (bsize_ff == '0) ? NW'(1)
                 : (bsize_ff > REG_W'(MAX_POSITIONS)) ? NW'(MAX_POSITIONS) : NW'(bsize_ff);
   assign ext_pos = NW'(in_pos);

   always_comb begin
      cur_in = cur_ff; bstart_in = bstart_ff; bend_in = bend_ff; lower_in = lower_ff;
      steps_in = steps_ff; total_in = total_ff; store_only_in = store_only_ff;
      phase_in = phase_ff;
      we = 1'b0; wa = cur_ff[AW-1:0]; wexit = erd_ff; whops = hrd_ff;
      done = 1'b0;
      len_use = (jrd_ff == '0) ? LEN_W'(1) : jrd_ff;
      tgt_w = TW'(cur_ff) + TW'(len_use);
      hsum = {1'b0, total_ff} + {1'b0, hrd_ff};
      rd_addr = cur_ff[AW-1:0];
      if (cmd.start) begin
         phase_in = 2'd0; steps_in = '0; total_in = '0;
         if (cmd.is_build) begin
            store_only_in = 1'b0; // resolved in init from n
            cur_in = '0;
         end else begin
            cur_in = ext_pos;
            store_only_in = (in_op == OP_LOAD);
         end
      end else if (!cmd.step) begin
         // init cycle: registers hold n/bs, set walk bounds
         if (op_ff == OP_BUILD) begin
            cur_in = n_ff - NW'(1);
            lower_in = '0;
            store_only_in = (n_ff == '0);
            bstart_in = '0; bend_in = '0; // block found by scan below
         end else if (op_ff == OP_UPDATE) begin
            store_only_in = (NW'(pos_ff) >= n_ff);
            lower_in = '0;
            bstart_in = '0; bend_in = '0;
         end else if (op_ff == OP_QUERY) begin
            store_only_in = (NW'(pos_ff) >= n_ff);
         end
         phase_in = 2'd3; // locate block first
      end else if (op_ff == OP_QUERY) begin
         if (phase_ff != 2'd1) begin
            phase_in = 2'd1; // read issued
         end else begin
            total_in = hsum[HOP_W] ? HOP_MAX : hsum[HOP_W-1:0];
            if (hsum > {1'b0, HOP_MAX}) total_in = HOP_MAX;
            cur_in = erd_ff;
            steps_in = steps_ff + NW'(1);
            phase_in = 2'd0;
            if (erd_ff >= n_ff || steps_ff + NW'(1) >= n_ff) done = 1'b1;
         end
      end else begin
         case (phase_ff)
            2'd3: begin
               // advance block window until it holds cur
               if (cur_ff >= bstart_ff + bs_ff) begin
                  bstart_in = bstart_ff + bs_ff;
               end else begin
                  bend_in = (n_ff - bstart_ff > bs_ff) ? bstart_ff + bs_ff : n_ff;
                  if (op_ff == OP_UPDATE) lower_in = bstart_ff;
                  phase_in = 2'd0;
               end
            end
            2'd0: phase_in = 2'd1; // jump read in flight
            2'd1: begin
               phase_in = 2'd2;
               rd_addr = (tgt_w < TW'(bend_ff)) ? tgt_w[AW-1:0] : cur_ff[AW-1:0];
            end
            default: begin
               we = 1'b1;
               if (tgt_w >= TW'(bend_ff)) begin
                  wexit = (tgt_w > TW'(n_ff)) ? n_ff : NW'(tgt_w);
                  whops = HOP_W'(1);
               end else begin
                  wexit = erd_ff;
                  whops = (hrd_ff == HOP_MAX) ? HOP_MAX : hrd_ff + HOP_W'(1);
               end
               if (cur_ff == lower_ff) done = 1'b1;
               else begin
                  cur_in = cur_ff - NW'(1);
                  if (cur_ff == bstart_ff) begin
                     bstart_in = bstart_ff - bs_ff;
                     bend_in = bstart_ff;
                  end
               end
               phase_in = 2'd0;
            end
         endcase
      end
   end

   // pointer read: target read in phase 1 for exits/hops
   always_ff @(posedge clock) begin
      jrd_ff <= jump_mem[cur_ff[AW-1:0]];
      erd_ff <= exit_mem[rd_addr];
      hrd_ff <= hops_mem[rd_addr];
      if (cmd.start && in_op != OP_BUILD && in_op != OP_QUERY
          && ext_pos < NW'(MAX_POSITIONS))
         jump_mem[in_pos[AW-1:0]] <= in_len;
      if (we) begin
         exit_mem[wa] <= wexit;
         hops_mem[wa] <= whops;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff <= in_op; pos_ff <= in_pos;
         n_ff <= n_eff; bs_ff <= bs_eff;
      end
      cur_ff <= cur_in; bstart_ff <= bstart_in; bend_ff <= bend_in;
      lower_ff <= lower_in; steps_ff <= steps_in; total_ff <= total_in;
      store_only_ff <= store_only_in; phase_ff <= phase_in;
   end

   assign sts.store_only = store_only_in && !cmd.start;
   assign sts.walk_done  = done;
   assign hop_count      = total_ff;
endmodule

>>> hdl/blocked_jump_count_table_top.sv
// Blocked jump count table: jump-chain hop counter with square-root blocking.
//
// req_ beats carry an operation (load, build, update, query), a position and
// a jump length. Only a query returns an rsp_ beat, the hop count from that
// position to the end of the active range. The csr_ port sets active_count
// (index 0) and block_size (index 1); write them only while the block is idle,
// which the block itself does not enforce. One item is in work at a time;
// req_tready is high only when idle. Load, and update or query at or past the
// active range, skip the walk. A query sums hops block by block through the
// single registered read port of the exit and hop tables. Update and build
// recompute entries downward after the start block is located (build covers
// all active_count entries).
// The rsp_ beat holds in its output register while rsp_tready is low and no
// new request is taken until the cycle after it leaves. Reset clears the
// controller and sets active_count to 4096 and block_size to 64; table
// contents are undefined until loaded and built.
module blocked_jump_count_table_top
   import bjct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // operation[1:0], position[13:2], jump_length[29:14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // hop_count[12:0]
   input  logic        csr_we,
   input  logic [0:0]  csr_idx,
   input  logic [12:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;
   logic [HOP_W-1:0] hop;

   bjct_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tdata[1:0]), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd(cmd), .sts(sts)
   );

   bjct_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_data(csr_wdata),
      .in_op(req_tdata[1:0]), .in_pos(req_tdata[13:2]), .in_len(req_tdata[29:14]),
      .cmd(cmd), .sts(sts), .hop_count(hop)
   );

   assign rsp_tdata = {3'b000, hop};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> req_tready) else $error("start outside idle");
`endif
endmodule

>>> dv/bjct_hop_checker.sv
// Hop count predictor and response checker for the blocked jump count table.
`timescale 1ns / 100ps
module bjct_hop_checker
   import bjct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_idx,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          hops_pending,
   output int          hops_checked
);
   localparam int TABLE_DEPTH = 4096;

   logic [REG_W-1:0] active_reg;
   logic [REG_W-1:0] block_reg;
   logic [LEN_W-1:0] jump_len [TABLE_DEPTH];
   logic [HOP_W-1:0] exit_pos [TABLE_DEPTH];
   logic [HOP_W-1:0] exit_hops [TABLE_DEPTH];
   logic [HOP_W-1:0] expected_hops [$];

   function automatic int span_count();
      return (active_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_reg);
   endfunction

   function automatic int span_block();
      return (block_reg == 0) ? 1 : int'(block_reg);
   endfunction

   // entries after i in its block must already be current
   function automatic void refresh_entry(int i, int n, int bs);
      int first;
      int stop;
      int len;
      int tgt;
      int h;
      first = (i / bs) * bs;
      stop = (n - first > bs) ? first + bs : n;
      len = (jump_len[i] == 0) ? 1 : int'(jump_len[i]);
      tgt = i + len;
      if (tgt >= stop) begin
         exit_pos[i] = (tgt > n) ? n[HOP_W-1:0] : tgt[HOP_W-1:0];
         exit_hops[i] = 1;
      end else begin
         h = int'(exit_hops[tgt]) + 1;
         exit_pos[i] = exit_pos[tgt];
         exit_hops[i] = (h > int'(HOP_MAX)) ? HOP_MAX : h[HOP_W-1:0];
      end
   endfunction

   function automatic logic [HOP_W-1:0] walk_hops(int pos);
      int n;
      int total;
      int steps;
      int p;
      n = span_count();
      total = 0;
      steps = 0;
      p = pos;
      while (p < n && steps < n) begin
         total += int'(exit_hops[p]);
         if (total > int'(HOP_MAX)) total = int'(HOP_MAX);
         p = int'(exit_pos[p]);
         steps++;
      end
      return total[HOP_W-1:0];
   endfunction

   function automatic void apply_beat(logic [1:0] op, int pos, logic [LEN_W-1:0] len);
      int n;
      int bs;
      int i;
      n = span_count();
      bs = span_block();
      case (op)
         OP_LOAD: begin
            jump_len[pos] = len;
         end
         OP_BUILD: begin
            for (i = n - 1; i >= 0; i--) refresh_entry(i, n, bs);
         end
         OP_UPDATE: begin
            jump_len[pos] = len;
            if (pos < n)
               for (i = pos; i >= (pos / bs) * bs; i--) refresh_entry(i, n, bs);
         end
         default: begin
            expected_hops.push_back(walk_hops(pos));
         end
      endcase
   endfunction

   task automatic report_fail(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      hops_checked = 0;
   end

   assign hops_pending = expected_hops.size();

   always @(posedge clock) begin
      if (reset) begin
         active_reg <= 13'd4096;
         block_reg <= 13'd64;
         expected_hops.delete();
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_ACTIVE) active_reg <= csr_wdata;
            else block_reg <= csr_wdata;
         end
         if (req_tvalid && req_tready)
            apply_beat(req_tdata[1:0], int'(req_tdata[13:2]), req_tdata[29:14]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hops.size() == 0) begin
               report_fail($sformatf("unexpected result beat, hop_count %0d",
                                     rsp_tdata[12:0]));
            end else begin
               if (rsp_tdata[12:0] !== expected_hops[0])
                  report_fail($sformatf("hop_count got %0d want %0d",
                                        rsp_tdata[12:0], expected_hops[0]));
               void'(expected_hops.pop_front());
               hops_checked++;
            end
         end
      end
   end
endmodule

>>> dv/blocked_jump_count_table_top_tb.sv
// Stimulus, handshake pacing and verdict for the blocked jump count table.
`timescale 1ns / 100ps
module blocked_jump_count_table_top_tb;
   import bjct_pkg::*;

   localparam int IDLE_LIMIT = 200000;
   localparam int NUM_PHASES = 8;
   localparam int LOAD_SPAN = 320;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [0:0]  csr_idx;
   logic [12:0] csr_wdata;
   int          fail_count;
   int          hops_pending;
   int          hops_checked;

   int burst_left;
   int idle_cycles;
   int stall_mode;
   int stall_left;
   int beats_sent;
   int cur_active;

   // active counts stay within the loaded span so no walk reads an unwritten entry
   int phase_active [NUM_PHASES] = '{100, 1, 320, 0, 64, 257, 320, 50};
   int phase_block  [NUM_PHASES] = '{10, 1, 4096, 0, 8191, 64, 1, 7};
   int phase_items  [NUM_PHASES] = '{80, 40, 40, 40, 40, 80, 30, 80};

   blocked_jump_count_table_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   bjct_hop_checker hop_chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .hops_pending(hops_pending),
      .hops_checked(hops_checked)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // receiver: switches between always ready, coin flip and mostly stalled
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(5, 80);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("blocked_jump_count_table_top_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_beat(input logic [1:0] op, input int pos, input int len);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, len[15:0], pos[11:0], op};
      do @(posedge clock); while (!req_tready);
      burst_left--;
      beats_sent++;
   endtask

   // block is idle only once every hop count is back and it takes beats again
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (hops_pending != 0);
      repeat (4) @(posedge clock);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic [0:0] idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= value[12:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(1, 8);
      if (r < 80) return $urandom_range(1, 64);
      if (r < 83) return 0;
      return $urandom_range(0, 65535);
   endfunction

   function automatic int pick_pos();
      int span;
      span = (cur_active > 4096) ? 4096 : cur_active;
      if (span > 0 && $urandom_range(0, 9) < 7) return $urandom_range(0, span - 1);
      return $urandom_range(0, 4095);
   endfunction

   task automatic random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) send_beat(OP_QUERY, pick_pos(), pick_len());
      else if (r < 80) send_beat(OP_UPDATE, pick_pos(), pick_len());
      else if (r < 96) send_beat(OP_LOAD, pick_pos(), pick_len());
      else send_beat(OP_BUILD, $urandom_range(0, 4095), $urandom_range(0, 65535));
   endtask

   initial begin
      int i;
      int ph;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_idx = CSR_ACTIVE;
      csr_wdata = '0;
      burst_left = 0;
      idle_cycles = 0;
      stall_mode = 0;
      stall_left = 0;
      beats_sent = 0;
      cur_active = 4096;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every entry of the span gets a length and a full build
      write_csr(CSR_ACTIVE, LOAD_SPAN);
      cur_active = LOAD_SPAN;
      for (i = 0; i < LOAD_SPAN; i++) send_beat(OP_LOAD, i, pick_len());
      send_beat(OP_BUILD, 0, 1);

      // directed: field extremes, zero length, stale query, block-edge updates
      send_beat(OP_QUERY, 0, 0);
      send_beat(OP_QUERY, 4095, 65535);
      send_beat(OP_UPDATE, 0, 65535);
      send_beat(OP_QUERY, 0, 1);
      send_beat(OP_UPDATE, 4095, 0);
      send_beat(OP_QUERY, 4095, 0);
      send_beat(OP_UPDATE, 63, 1);
      send_beat(OP_UPDATE, 64, 0);
      send_beat(OP_QUERY, 63, 1);
      send_beat(OP_LOAD, 5, 4000);
      send_beat(OP_QUERY, 0, 1);
      send_beat(OP_BUILD, 4095, 65535);
      send_beat(OP_QUERY, 0, 1);
      send_beat(OP_QUERY, 2048, 1);
      send_beat(OP_LOAD, 4095, 65535);
      send_beat(OP_UPDATE, 2047, 1);
      send_beat(OP_QUERY, 2000, 1);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         write_csr(CSR_ACTIVE, phase_active[ph]);
         write_csr(CSR_BLOCK, phase_block[ph]);
         cur_active = phase_active[ph];
         // now and then skip the rebuild to query stale tables
         if ($urandom_range(0, 4) != 0) send_beat(OP_BUILD, 0, 1);
         for (i = 0; i < phase_items[ph]; i++) random_beat();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("sent %0d beats over %0d register settings, %0d hop counts checked",
               beats_sent, NUM_PHASES + 1, hops_checked);
      if (fail_count == 0) begin
         $display("blocked_jump_count_table_top_tb: PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("blocked_jump_count_table_top_tb: FAIL");
      end
      $finish;
   end
endmodule

>>> filelist.f
hdl/bjct_pkg.sv
hdl/bjct_ctrl.sv
hdl/bjct_dp.sv
hdl/blocked_jump_count_table_top.sv
dv/bjct_hop_checker.sv
dv/blocked_jump_count_table_top_tb.sv
